FILE: hdl/c2p_pkg.sv
// shared types, constants and the arctangent table for cartesian_to_polar
package c2p_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD_BITS    = 8;
  localparam int TABLE_LEN     = 24;

  // magnitude of a coordinate, one bit more to hold the most negative value
  localparam int ABS_W = COORD_WIDTH + 1;
  // sum of squares and square root remainder
  localparam int SQ_W  = 2 * COORD_WIDTH;
  // cordic x and y, with room for the cordic gain
  localparam int XY_W  = ABS_W + GUARD_BITS + 3;
  // angle accumulator, degrees in q.16
  localparam int Z_W   = 25;

  localparam int N_CELLS = (CORDIC_STAGES > COORD_WIDTH) ? CORDIC_STAGES : COORD_WIDTH;
  localparam int IDX_W   = $clog2(N_CELLS);

  localparam int ANG_W = 17;
  localparam int MAG_W = 16;

  // angle constants in q9.7 degrees
  localparam int DEG90  = 11520;
  localparam int DEG180 = 23040;
  localparam int DEG270 = 34560;
  localparam int DEG360 = 46080;

  localparam int DEG90_Q16   = DEG90 * 512;
  localparam int ANGLE_SHIFT = 9;
  localparam int ROUND_HALF  = 256;
  localparam int MAG_MAX     = (1 << MAG_W) - 1;

  typedef struct packed {
    logic valid;
    logic xzero;
    logic yzero;
    logic xneg;
    logic yneg;
  } ctl_t;

  typedef struct packed {
    logic [XY_W-1:0] cx;
    logic [XY_W-1:0] cy;
    logic [Z_W-1:0]  z;
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } cell_data_t;

  // round(atan(2^-i) * 65536) in degrees
  function automatic logic [Z_W-1:0] atan_q16(input logic [IDX_W-1:0] i);
    logic [Z_W-1:0] v;
    case (int'(i))
      0:       v = Z_W'(2949120);
      1:       v = Z_W'(1740967);
      2:       v = Z_W'(919879);
      3:       v = Z_W'(466945);
      4:       v = Z_W'(234379);
      5:       v = Z_W'(117304);
      6:       v = Z_W'(58666);
      7:       v = Z_W'(29335);
      8:       v = Z_W'(14668);
      9:       v = Z_W'(7334);
      10:      v = Z_W'(3667);
      11:      v = Z_W'(1833);
      12:      v = Z_W'(917);
      13:      v = Z_W'(458);
      14:      v = Z_W'(229);
      15:      v = Z_W'(115);
      16:      v = Z_W'(57);
      17:      v = Z_W'(29);
      18:      v = Z_W'(14);
      19:      v = Z_W'(7);
      20:      v = Z_W'(4);
      21:      v = Z_W'(2);
      22:      v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/c2p_front.sv
// input register, absolute values, squares and cell chain seed
module c2p_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic signed [c2p_pkg::COORD_WIDTH-1:0] x_coord,
  input  logic signed [c2p_pkg::COORD_WIDTH-1:0] y_coord,
  output c2p_pkg::ctl_t                       ctl_out,
  output c2p_pkg::cell_data_t                 d_out
);
  import c2p_pkg::*;

  logic signed [ABS_W-1:0] sx, sy;
  logic [ABS_W-1:0]        ax_in, ay_in;
  ctl_t                    ctl_in;

  ctl_t             a_ctl, b_ctl;
  logic [ABS_W-1:0] a_ax, a_ay, b_ax, b_ay;
  logic [SQ_W-1:0]  b_sqx, b_sqy;
  logic [2*ABS_W-1:0] prod_x, prod_y;

  assign sx = {x_coord[COORD_WIDTH-1], x_coord};
  assign sy = {y_coord[COORD_WIDTH-1], y_coord};
  assign ax_in = x_coord[COORD_WIDTH-1] ? -sx : sx;
  assign ay_in = y_coord[COORD_WIDTH-1] ? -sy : sy;

  always_comb begin
    ctl_in.valid = accept;
    ctl_in.xzero = (x_coord == '0);
    ctl_in.yzero = (y_coord == '0);
    ctl_in.xneg  = x_coord[COORD_WIDTH-1];
    ctl_in.yneg  = y_coord[COORD_WIDTH-1];
  end

  assign prod_x = a_ax * a_ax;
  assign prod_y = a_ay * a_ay;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl   <= '0;
      b_ctl   <= '0;
      ctl_out <= '0;
    end else begin
      a_ctl   <= ctl_in;
      b_ctl   <= a_ctl;
      ctl_out <= b_ctl;
    end
  end

  always_ff @(posedge clk) begin
    a_ax      <= ax_in;
    a_ay      <= ay_in;
    b_ax      <= a_ax;
    b_ay      <= a_ay;
    b_sqx     <= prod_x[SQ_W-1:0];
    b_sqy     <= prod_y[SQ_W-1:0];
    d_out.cx  <= {{(XY_W-ABS_W-GUARD_BITS){1'b0}}, b_ax, {GUARD_BITS{1'b0}}};
    d_out.cy  <= {{(XY_W-ABS_W-GUARD_BITS){1'b0}}, b_ay, {GUARD_BITS{1'b0}}};
    d_out.z   <= '0;
    d_out.rem <= b_sqx + b_sqy;
    d_out.res <= '0;
  end

endmodule

FILE: hdl/c2p_cell.sv
// one cell: a cordic vectoring step and a square root digit step
module c2p_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [c2p_pkg::IDX_W-1:0]   stage,
  input  c2p_pkg::ctl_t               ctl_in,
  input  c2p_pkg::cell_data_t         d_in,
  output c2p_pkg::ctl_t               ctl_out,
  output c2p_pkg::cell_data_t         d_out
);
  import c2p_pkg::*;

  logic signed [XY_W-1:0] cx_s, cy_s, dx, dy;
  logic [Z_W-1:0]         atan_v;
  logic [SQ_W-1:0]        sq_bit, trial;
  logic [SQ_W:0]          diff;
  logic                   cordic_on, sqrt_on;
  cell_data_t             d_next;

  assign cordic_on = (stage < CORDIC_STAGES) && (stage < TABLE_LEN);
  assign sqrt_on   = (stage < COORD_WIDTH);

  assign cx_s   = $signed(d_in.cx);
  assign cy_s   = $signed(d_in.cy);
  assign dx     = cy_s >>> stage;
  assign dy     = cx_s >>> stage;
  assign atan_v = atan_q16(stage);

  // digit weight 4^(n-1-stage)
  assign sq_bit = {1'b1, {(SQ_W-1){1'b0}}} >> {stage, 1'b1};
  assign trial  = d_in.res + sq_bit;
  assign diff   = {1'b0, d_in.rem} - {1'b0, trial};

  always_comb begin
    d_next = d_in;
    if (cordic_on) begin
      if (!cy_s[XY_W-1]) begin
        d_next.cx = cx_s + dx;
        d_next.cy = cy_s - dy;
        d_next.z  = d_in.z + atan_v;
      end else begin
        d_next.cx = cx_s - dx;
        d_next.cy = cy_s + dy;
        d_next.z  = d_in.z - atan_v;
      end
    end
    if (sqrt_on) begin
      if (!diff[SQ_W]) begin
        d_next.rem = diff[SQ_W-1:0];
        d_next.res = (d_in.res >> 1) + sq_bit;
      end else begin
        d_next.res = d_in.res >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    d_out <= d_next;
  end

endmodule

FILE: hdl/c2p_finish.sv
// angle rounding, quadrant placement, magnitude rounding and result register
module c2p_finish (
  input  logic                               clk,
  input  logic                               rst,
  input  c2p_pkg::ctl_t                      ctl_in,
  input  c2p_pkg::cell_data_t                d_in,
  output logic                               done,
  output logic signed [c2p_pkg::ANG_W-1:0]   angle_deg,
  output logic [c2p_pkg::MAG_W-1:0]          magnitude
);
  import c2p_pkg::*;

  logic [Z_W-1:0]    zc, zr;
  logic [ANG_W-1:0]  phi;
  logic [ANG_W:0]    ang, ang_w;
  logic [ANG_W-1:0]  ang_final;
  logic [SQ_W:0]     mag_r;
  logic [MAG_W-1:0]  mag_final;

  always_comb begin
    if (d_in.z[Z_W-1]) begin
      zc = '0;
    end else if (d_in.z > Z_W'(DEG90_Q16)) begin
      zc = Z_W'(DEG90_Q16);
    end else begin
      zc = d_in.z;
    end
    zr  = (zc + Z_W'(ROUND_HALF)) >> ANGLE_SHIFT;
    phi = ctl_in.yzero ? '0 : zr[ANG_W-1:0];

    if (!ctl_in.xneg) begin
      ang = ctl_in.yneg ? ((ANG_W+1)'(DEG360) - {1'b0, phi}) : {1'b0, phi};
    end else begin
      ang = ctl_in.yneg ? ((ANG_W+1)'(DEG180) + {1'b0, phi})
                        : ((ANG_W+1)'(DEG180) - {1'b0, phi});
    end
    // wraps a full turn back to zero
    ang_w = (ang >= (ANG_W+1)'(DEG360)) ? (ang - (ANG_W+1)'(DEG360)) : ang;

    if (ctl_in.xzero && ctl_in.yzero) begin
      ang_final = '1;
    end else if (ctl_in.xzero) begin
      ang_final = ctl_in.yneg ? ANG_W'(DEG270) : ANG_W'(DEG90);
    end else begin
      ang_final = ang_w[ANG_W-1:0];
    end

    mag_r = {1'b0, d_in.res} + (SQ_W+1)'(d_in.rem > d_in.res);
    if (mag_r > (SQ_W+1)'(MAG_MAX)) begin
      mag_final = MAG_W'(MAG_MAX);
    end else begin
      mag_final = mag_r[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    angle_deg <= $signed(ang_final);
    magnitude <= mag_final;
  end

endmodule

FILE: hdl/cartesian_to_polar.sv
// top level: pipelined cartesian to polar conversion
//
// usage
//   an item (x_coord, y_coord, signed q8.8) is taken at each rising edge with
//   start high and busy low; busy is low except during reset, so a new item
//   may be offered in every cycle
//   results come out in order: done is high for exactly one cycle with
//   angle_deg (q9.7 degrees in [0,360), all ones for the origin) and
//   magnitude (q8.8, rounded) valid in that same cycle
//   throughput: one result per cycle sustained outside reset
//   the pipeline is three front stages (input, squares, seed), a chain of
//   N_CELLS cells, each one cordic rotation plus one square root digit, and
//   one output stage; the chain length sets the latency
//   the receiver cannot stall: done is a strobe and each item leaves once
//   reset (synchronous, active high) empties the pipeline; items in flight
//   are dropped and done stays low until new items reach the end
module cartesian_to_polar (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [c2p_pkg::COORD_WIDTH-1:0] x_coord,
  input  logic signed [c2p_pkg::COORD_WIDTH-1:0] y_coord,
  output logic                                   done,
  output logic signed [c2p_pkg::ANG_W-1:0]       angle_deg,
  output logic [c2p_pkg::MAG_W-1:0]              magnitude
);
  import c2p_pkg::*;

  // edges from acceptance to the edge at which done is seen high
  localparam int LATENCY = N_CELLS + 4;

  logic       accept;
  ctl_t       chain_ctl [N_CELLS+1];
  cell_data_t chain_d   [N_CELLS+1];

  // only reset holds items off
  assign busy   = rst;
  assign accept = start && !busy;

  // abs values, squares, cordic and root seed
  c2p_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .x_coord (x_coord),
    .y_coord (y_coord),
    .ctl_out (chain_ctl[0]),
    .d_out   (chain_d[0])
  );

  // cell k does cordic rotation k and root digit k
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    c2p_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .stage   (IDX_W'(k)),
      .ctl_in  (chain_ctl[k]),
      .d_in    (chain_d[k]),
      .ctl_out (chain_ctl[k+1]),
      .d_out   (chain_d[k+1])
    );
  end

  // quadrant placement, special cases and rounding
  c2p_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (chain_ctl[N_CELLS]),
    .d_in      (chain_d[N_CELLS]),
    .done      (done),
    .angle_deg (angle_deg),
    .magnitude (magnitude)
  );

  // every result traces back to an item that was accepted earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a matching item");

  // the origin marker comes only with a zero magnitude, and the reverse
  a_origin_mag: assert property (@(posedge clk) disable iff (rst)
    (done && (angle_deg == '1)) |-> (magnitude == '0))
    else $error("origin angle with nonzero magnitude");

  a_zero_mag: assert property (@(posedge clk) disable iff (rst)
    (done && (magnitude == '0)) |-> (angle_deg == '1))
    else $error("zero magnitude without origin angle");

  // any other angle stays below a full turn
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    (done && (angle_deg != '1)) |->
      (!angle_deg[ANG_W-1] && ($unsigned(angle_deg) < ANG_W'(DEG360))))
    else $error("angle out of range");

endmodule
